FILE: rtl/core/fern_ensemble_posterior_engine_core_assert.svh
// Assertion macros shared by the checker of the fern ensemble engine.
// Each macro expands to one labeled concurrent assertion clocked on the
// rising edge and switched off while the asynchronous reset is low.
`ifndef FERN_ENSEMBLE_POSTERIOR_ENGINE_CORE_ASSERT_SVH
`define FERN_ENSEMBLE_POSTERIOR_ENGINE_CORE_ASSERT_SVH

// Same-cycle implication: the consequent holds wherever the antecedent does.
`define FEPE_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("fepe checker: same-cycle property failed");

// Next-cycle implication: the consequent holds in the cycle after the antecedent.
`define FEPE_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("fepe checker: next-cycle property failed");

`endif

FILE: rtl/core/fepe_pkg.sv
// ----------------------------------------------------------------------------
// fepe_pkg
// Shared constants, payload types and controller/datapath interface types of
// the fern ensemble posterior engine.
// ----------------------------------------------------------------------------
package fepe_pkg;

	// Ensemble geometry.
	localparam int NUM_TREES      = 10;
	localparam int NUM_FEATURES   = 13;
	localparam int COUNT_WIDTH    = 16;

	// Fixed field widths.
	localparam int CODE_W         = 13;
	localparam int CONF_W         = 19;
	localparam int THR_W          = 20;
	localparam int POST_W         = 16;
	localparam int CFG_IDX_W      = 2;
	localparam int CFG_DATA_W     = 20;

	// Derived table geometry.
	localparam int CODES_PER_TREE = 1 << NUM_FEATURES;
	localparam int TABLE_SIZE     = NUM_TREES * CODES_PER_TREE;
	localparam int ADDR_W         = $clog2(TABLE_SIZE);
	localparam int TREE_W         = (NUM_TREES > 1) ? $clog2(NUM_TREES) : 1;
	localparam int WORD_W         = POST_W + 2 * COUNT_WIDTH;

	// Divider geometry: one quotient bit per step.
	localparam int DEN_W          = COUNT_WIDTH + 1;
	localparam int REM_W          = COUNT_WIDTH + 2;
	localparam int STEP_W         = $clog2(POST_W);

	// Configuration reset values (0.5, 0.4 and 0.6 in Q1.15).
	localparam logic              ENABLE_RST     = 1'b1;
	localparam logic [THR_W-1:0]  DETECT_THR_RST = THR_W'(16384);
	localparam logic [THR_W-1:0]  LEARN_POS_RST  = THR_W'(13107);
	localparam logic [THR_W-1:0]  LEARN_NEG_RST  = THR_W'(19661);

	// Operation codes.
	localparam logic OP_CLASSIFY = 1'b0;
	localparam logic OP_LEARN    = 1'b1;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ENABLE     = 2'd0,
		CFG_DETECT_THR = 2'd1,
		CFG_LEARN_POS  = 2'd2,
		CFG_LEARN_NEG  = 2'd3
	} cfg_idx_t;

	// Input beat.
	typedef struct packed {
		logic              op;
		logic [CODE_W-1:0] fern_code;
		logic              label_positive;
	} in_item_t;

	// Result beat.
	typedef struct packed {
		logic [CONF_W-1:0] confidence;
		logic              accepted;
		logic              updated;
	} out_item_t;

	// One table entry: posterior and the two counts of one fern leaf.
	typedef struct packed {
		logic [POST_W-1:0]      posterior;
		logic [COUNT_WIDTH-1:0] pos_count;
		logic [COUNT_WIDTH-1:0] neg_count;
	} tbl_word_t;

	// Controller to datapath commands.
	typedef struct packed {
		logic clr_wr;
		logic capture;
		logic rd_look;
		logic sum;
		logic load_out;
		logic rd_upd;
		logic bump;
		logic div_step;
		logic tbl_wr;
	} cmd_t;

	// Datapath to controller status.
	typedef struct packed {
		logic clr_last;
		logic last_tree;
		logic do_update;
		logic div_last;
		logic upd_last;
	} status_t;

endpackage

FILE: rtl/core/fepe_ram.sv
// ----------------------------------------------------------------------------
// fepe_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module fepe_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	clk,
	we,
	waddr,
	wdata,
	re,
	raddr,
	rdata
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	input  logic             clk;
	input  logic             we;
	input  logic [AW-1:0]    waddr;
	input  logic [WIDTH-1:0] wdata;
	input  logic             re;
	input  logic [AW-1:0]    raddr;
	output logic [WIDTH-1:0] rdata;

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/core/fepe_ctrl.sv
// ----------------------------------------------------------------------------
// fepe_ctrl
// Controller of the fern ensemble engine: table clearing after reset, the
// per-tree read and accumulate sequence, result hand-off and the learn pass.
// ----------------------------------------------------------------------------
module fepe_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_ready,
	output logic             result_valid,
	input  logic             result_ready,
	output fepe_pkg::cmd_t   cmd,
	input  fepe_pkg::status_t status
);
	import fepe_pkg::*;

	typedef enum logic [8:0] {
		S_CLEAR  = 9'b000000001,
		S_IDLE   = 9'b000000010,
		S_LOOK   = 9'b000000100,
		S_SUM    = 9'b000001000,
		S_RESULT = 9'b000010000,
		S_URD    = 9'b000100000,
		S_UBUMP  = 9'b001000000,
		S_UDIV   = 9'b010000000,
		S_UWR    = 9'b100000000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;

	// Next state and command decode.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (status.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (item_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_LOOK;
				end
			end
			S_LOOK: begin
				cmd.rd_look = 1'b1;
				state_d     = S_SUM;
			end
			S_SUM: begin
				cmd.sum = 1'b1;
				state_d = status.last_tree ? S_RESULT : S_IDLE;
			end
			S_RESULT: begin
				if (!out_valid_q) begin
					cmd.load_out = 1'b1;
					state_d      = status.do_update ? S_URD : S_IDLE;
				end
			end
			S_URD: begin
				cmd.rd_upd = 1'b1;
				state_d    = S_UBUMP;
			end
			S_UBUMP: begin
				cmd.bump = 1'b1;
				state_d  = S_UDIV;
			end
			S_UDIV: begin
				cmd.div_step = 1'b1;
				if (status.div_last) begin
					state_d = S_UWR;
				end
			end
			S_UWR: begin
				cmd.tbl_wr = 1'b1;
				state_d    = status.upd_last ? S_IDLE : S_URD;
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
	end

	// State register and result-valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign item_ready   = (state_q == S_IDLE);
	assign result_valid = out_valid_q;

endmodule

FILE: rtl/core/fepe_dp.sv
// ----------------------------------------------------------------------------
// fepe_dp
// Datapath of the fern ensemble engine: configuration registers, the fern
// table memory, the confidence accumulator, the bit-serial posterior divider
// and the result register.
// ----------------------------------------------------------------------------
module fepe_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write,
	input  logic [fepe_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [fepe_pkg::CFG_DATA_W-1:0] cfg_data,
	input  fepe_pkg::in_item_t            item,
	input  fepe_pkg::cmd_t                cmd,
	output fepe_pkg::status_t             status,
	output fepe_pkg::out_item_t           result
);
	import fepe_pkg::*;

	// Configuration.
	logic              enable_q;
	logic [THR_W-1:0]  detect_thr_q;
	logic [THR_W-1:0]  learn_pos_q;
	logic [THR_W-1:0]  learn_neg_q;

	// Window state.
	logic [TREE_W-1:0]       tree_q;
	logic [CONF_W-1:0]       sum_q;
	logic [NUM_FEATURES-1:0] window_codes_q [NUM_TREES];
	logic [NUM_FEATURES-1:0] code_q;
	logic                    op_q;
	logic                    label_q;
	logic [CONF_W-1:0]       win_conf_q;

	// Clearing pass and learn pass.
	logic [ADDR_W-1:0]       clr_addr_q;
	logic [TREE_W-1:0]       upd_tree_q;

	// Divider.
	logic [COUNT_WIDTH-1:0]  pos_q;
	logic [COUNT_WIDTH-1:0]  neg_q;
	logic [DEN_W-1:0]        den_q;
	logic [REM_W-1:0]        rem_q;
	logic [POST_W-1:0]       quot_q;
	logic [STEP_W-1:0]       step_q;

	out_item_t result_q;
	out_item_t result_d;

	// Table port signals.
	logic [WORD_W-1:0] rdata_raw;
	tbl_word_t         rword;
	tbl_word_t         wword;
	logic [ADDR_W-1:0] look_addr;
	logic [ADDR_W-1:0] upd_addr;
	logic [ADDR_W-1:0] raddr;
	logic [ADDR_W-1:0] waddr;
	logic [WORD_W-1:0] wdata;
	logic              we;
	logic              re;

	// Arithmetic.
	logic [CONF_W:0]        sum_ext;
	logic [CONF_W-1:0]      sum_sat;
	logic [COUNT_WIDTH-1:0] pos_new;
	logic [COUNT_WIDTH-1:0] neg_new;
	logic [REM_W-1:0]       trial;
	logic [REM_W-1:0]       den_ext;
	logic                   q_bit;
	logic                   upd_cond;

	// Table addressing: tree index above the masked fern code.
	assign look_addr = ADDR_W'({tree_q, code_q});
	assign upd_addr  = ADDR_W'({upd_tree_q, window_codes_q[upd_tree_q]});
	assign raddr     = cmd.rd_look ? look_addr : upd_addr;
	assign re        = cmd.rd_look | cmd.rd_upd;

	always_comb begin
		wword.posterior = quot_q;
		wword.pos_count = pos_q;
		wword.neg_count = neg_q;
	end

	assign we    = cmd.clr_wr | cmd.tbl_wr;
	assign waddr = cmd.clr_wr ? clr_addr_q : upd_addr;
	assign wdata = cmd.clr_wr ? '0 : WORD_W'(wword);

	fepe_ram #(
		.WIDTH(WORD_W),
		.DEPTH(TABLE_SIZE)
	) u_table (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (re),
		.raddr(raddr),
		.rdata(rdata_raw)
	);

	assign rword = tbl_word_t'(rdata_raw);

	// Saturating confidence accumulate.
	assign sum_ext = {1'b0, sum_q} + (CONF_W + 1)'(rword.posterior);
	assign sum_sat = sum_ext[CONF_W] ? '1 : sum_ext[CONF_W-1:0];

	// Saturating count bump for the label of the window.
	assign pos_new = (label_q && (rword.pos_count != '1)) ?
		rword.pos_count + COUNT_WIDTH'(1) : rword.pos_count;
	assign neg_new = (!label_q && (rword.neg_count != '1)) ?
		rword.neg_count + COUNT_WIDTH'(1) : rword.neg_count;

	// Restoring divider step: the first step compares the count itself, later
	// steps shift the remainder left by one.
	assign trial   = (step_q == '0) ? rem_q : {rem_q[REM_W-2:0], 1'b0};
	assign den_ext = REM_W'(den_q);
	assign q_bit   = (trial >= den_ext);

	// Learn decision on the window confidence.
	assign upd_cond = label_q ? ({1'b0, win_conf_q} < learn_pos_q) :
		({1'b0, win_conf_q} > learn_neg_q);

	// Result formation.
	always_comb begin
		result_d = '0;
		if (op_q == OP_LEARN) begin
			if (enable_q) begin
				result_d.confidence = win_conf_q;
				result_d.updated    = upd_cond;
			end
		end else begin
			if (enable_q) begin
				result_d.confidence = win_conf_q;
				result_d.accepted   = ({1'b0, win_conf_q} >= detect_thr_q);
			end else begin
				result_d.accepted = 1'b1;
			end
		end
	end

	// Status to the controller.
	assign status.clr_last  = (clr_addr_q == ADDR_W'(TABLE_SIZE - 1));
	assign status.last_tree = (tree_q == TREE_W'(NUM_TREES - 1));
	assign status.do_update = (op_q == OP_LEARN) && enable_q && upd_cond;
	assign status.div_last  = (step_q == STEP_W'(POST_W - 1));
	assign status.upd_last  = (upd_tree_q == TREE_W'(NUM_TREES - 1));

	// Control state: configuration, counters and accumulator.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q     <= ENABLE_RST;
			detect_thr_q <= DETECT_THR_RST;
			learn_pos_q  <= LEARN_POS_RST;
			learn_neg_q  <= LEARN_NEG_RST;
			tree_q       <= '0;
			sum_q        <= '0;
			clr_addr_q   <= '0;
			upd_tree_q   <= '0;
			step_q       <= '0;
		end else begin
			if (cfg_write) begin
				unique case (cfg_idx_t'(cfg_index))
					CFG_ENABLE:     enable_q     <= cfg_data[0];
					CFG_DETECT_THR: detect_thr_q <= cfg_data[THR_W-1:0];
					CFG_LEARN_POS:  learn_pos_q  <= cfg_data[THR_W-1:0];
					CFG_LEARN_NEG:  learn_neg_q  <= cfg_data[THR_W-1:0];
					default: ;
				endcase
			end
			if (cmd.clr_wr) begin
				clr_addr_q <= clr_addr_q + ADDR_W'(1);
			end
			if (cmd.sum) begin
				if (status.last_tree) begin
					tree_q <= '0;
					sum_q  <= '0;
				end else begin
					tree_q <= tree_q + TREE_W'(1);
					sum_q  <= sum_sat;
				end
			end
			if (cmd.load_out) begin
				upd_tree_q <= '0;
			end else if (cmd.tbl_wr) begin
				upd_tree_q <= upd_tree_q + TREE_W'(1);
			end
			if (cmd.bump) begin
				step_q <= '0;
			end else if (cmd.div_step) begin
				step_q <= step_q + STEP_W'(1);
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			code_q                 <= item.fern_code[NUM_FEATURES-1:0];
			op_q                   <= item.op;
			label_q                <= item.label_positive;
			window_codes_q[tree_q] <= item.fern_code[NUM_FEATURES-1:0];
		end
		if (cmd.sum && status.last_tree) begin
			win_conf_q <= sum_sat;
		end
		if (cmd.load_out) begin
			result_q <= result_d;
		end
		if (cmd.bump) begin
			pos_q  <= pos_new;
			neg_q  <= neg_new;
			den_q  <= {1'b0, pos_new} + {1'b0, neg_new};
			rem_q  <= REM_W'(pos_new);
			quot_q <= '0;
		end else if (cmd.div_step) begin
			rem_q  <= q_bit ? (trial - den_ext) : trial;
			quot_q <= {quot_q[POST_W-2:0], q_bit};
		end
	end

	assign result = result_q;

endmodule

FILE: rtl/core/fern_ensemble_posterior_engine_core.sv
// ----------------------------------------------------------------------------
// fern_ensemble_posterior_engine_core
// Random-fern ensemble classifier with on-line learning of the leaf
// posteriors.
// ----------------------------------------------------------------------------
// A window arrives as one input beat per tree in tree order. Each beat is
// accepted, its fern table entry is read and its posterior is accumulated
// before the next beat is taken. After the last beat of a window the result
// is handed to the output register, which waits there while the next window's
// beats are taken. A learn window that updates the tables then runs a
// read-modify-write for each of the ten trees (read, count bump, 16 steps of
// the bit-serial posterior divider, write) before the next beat is taken.
// After reset all TABLE_SIZE (81920) entries of the table memory are cleared,
// one entry per cycle, with item_ready low; configuration writes are taken
// throughout.
module fern_ensemble_posterior_engine_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_write,
	input  logic [fepe_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [fepe_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            item_valid,
	output logic                            item_ready,
	input  fepe_pkg::in_item_t              item,
	output logic                            result_valid,
	input  logic                            result_ready,
	output fepe_pkg::out_item_t             result
);
	import fepe_pkg::*;

	cmd_t    cmd;
	status_t status;

	// Sequencer.
	fepe_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.cmd         (cmd),
		.status      (status)
	);

	// Tables, accumulator and divider.
	fepe_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.item     (item),
		.cmd      (cmd),
		.status   (status),
		.result   (result)
	);

endmodule

FILE: rtl/core/fepe_checker.sv
// ----------------------------------------------------------------------------
// fepe_checker
// Port-level assertions for the fern ensemble engine, bound to the top level.
// ----------------------------------------------------------------------------
`include "fern_ensemble_posterior_engine_core_assert.svh"

module fepe_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            item_valid,
	input logic                            item_ready,
	input logic                            result_valid,
	input logic                            result_ready,
	input fepe_pkg::out_item_t             result
);
	import fepe_pkg::*;

	// A stalled result beat holds its value.
	`FEPE_ASSERT_NEXT(a_result_hold, clk, arst_n, result_valid && !result_ready, result_valid && $stable(result))

	// A result is either a classify decision or a learn update, never both.
	`FEPE_ASSERT_SAME(a_accept_update_excl, clk, arst_n, result_valid, !(result.accepted && result.updated))

	// The table clearing pass keeps the input closed right after reset.
	`FEPE_ASSERT_SAME(a_clear_after_reset, clk, arst_n, !$past(arst_n), !item_ready)

	// Each input beat is read and accumulated before the next is taken, so ready drops after an accept.
	`FEPE_ASSERT_NEXT(a_item_one_at_a_time, clk, arst_n, item_valid && item_ready, !item_ready)

	// A new result is loaded only while none is held, so valid drops after a taken beat.
	`FEPE_ASSERT_NEXT(a_result_gap, clk, arst_n, result_valid && result_ready, !result_valid)

endmodule

bind fern_ensemble_posterior_engine_core fepe_checker u_checker (.*);
